// ----- rtl/audio_peak_overview_decimator_top_defines.svh -----
// Assertion macros used by the peak decimator checker
`ifndef AUDIO_PEAK_OVERVIEW_DECIMATOR_TOP_DEFINES_SVH
`define AUDIO_PEAK_OVERVIEW_DECIMATOR_TOP_DEFINES_SVH

// same-cycle implication, inactive during reset
`define APD_ASSERT_HOLDS(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, inactive during reset
`define APD_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/apd_pkg.sv -----
package apd_pkg;

  // defaults for the top level parameters
  localparam int MAX_CHANNELS_DEF  = 8;
  localparam int BLOCK_SAMPLES_DEF = 256;

  // fixed field widths
  localparam int SAMPLE_BITS = 24;
  localparam int SCALE_BITS  = 15;              // x*32767 == (x << 15) - x
  localparam int LOW_W       = SCALE_BITS + 1;
  localparam int CH_W        = 3;
  localparam int CFG_W       = 4;

  localparam logic [CFG_W-1:0] CFG_COUNT_RESET = 4'd2;

  // request kinds carried on s_tuser
  localparam logic FUNC_SAMPLE = 1'b0;
  localparam logic FUNC_FLUSH  = 1'b1;

  // stream widths
  localparam int IN_TDATA_W  = 32;
  localparam int OUT_TDATA_W = 96;

  // input tdata layout
  localparam int IN_CH_LSB  = 0;
  localparam int IN_SMP_LSB = CH_W;

  // output tdata layout
  localparam int OUT_CH_LSB = 0;
  localparam int PH_LSB     = OUT_CH_LSB + CH_W;
  localparam int PL_LSB     = PH_LSB + SCALE_BITS;
  localparam int MH_LSB     = PL_LSB + LOW_W;
  localparam int ML_LSB     = MH_LSB + SCALE_BITS;
  localparam int MP_LSB     = ML_LSB + LOW_W;
  localparam int OUT_USED_W = MP_LSB + SAMPLE_BITS;

  localparam logic [SAMPLE_BITS-1:0] FULL_SCALE = 24'h800000;

  // magnitude * 32767 >> 23, truncating
  function automatic logic [SCALE_BITS-1:0] scale_mag(input logic [SAMPLE_BITS-1:0] m);
    logic [SAMPLE_BITS+SCALE_BITS-1:0] p;
    p = {m, {SCALE_BITS{1'b0}}} - {{SCALE_BITS{1'b0}}, m};
    return p[SAMPLE_BITS-1 +: SCALE_BITS];
  endfunction

endpackage

// ----- rtl/audio_peak_overview_decimator_top.sv -----
// Samples and ignored/empty-flush requests: one per cycle while s_tready is high, peak memory written the cycle after.
// Block close (full block or flush): s_tready drops while a scan pass over the n channels in use
// finds the block max and min, then a second pass reads each channel and emits one result per channel,
// both passes going through the single read port of the per-channel peak memory.
// Reset (rst, synchronous) clears control, per-channel valid bits (peaks read as zero),
// frame count, overall peak and sets channel_count to 2; no memory clearing pass.
module audio_peak_overview_decimator_top #(
  parameter int MAX_CHANNELS  = apd_pkg::MAX_CHANNELS_DEF,
  parameter int BLOCK_SAMPLES = apd_pkg::BLOCK_SAMPLES_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_we,
  input  logic [apd_pkg::CFG_W-1:0]         cfg_wdata,
  input  logic                              s_tvalid,
  output logic                              s_tready,
  // [2:0] channel, [26:3] sample, [31:27] zero
  input  logic [apd_pkg::IN_TDATA_W-1:0]    s_tdata,
  // [0] func
  input  logic [0:0]                        s_tuser,
  output logic                              m_tvalid,
  input  logic                              m_tready,
  // [2:0] out_channel, [17:3] peak_high, [33:18] peak_low, [48:34] mix_high,
  // [64:49] mix_low, [88:65] max_peak, [95:89] zero
  output logic [apd_pkg::OUT_TDATA_W-1:0]   m_tdata,
  output logic                              m_tlast
);

  localparam int SB = apd_pkg::SAMPLE_BITS;
  localparam int SW = apd_pkg::SCALE_BITS;
  localparam int LW = apd_pkg::LOW_W;
  localparam int AW = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
  localparam int CW = $clog2(MAX_CHANNELS + 1);
  localparam int FW = $clog2(BLOCK_SAMPLES + 1);
  localparam int DW = 2 * SB;

  typedef enum logic [9:0] {
    ST_IDLE  = 10'b0000000001,
    ST_DRAIN = 10'b0000000010,
    ST_SCAN  = 10'b0000000100,
    ST_NEG   = 10'b0000001000,
    ST_MAG   = 10'b0000010000,
    ST_MIX   = 10'b0000100000,
    ST_RD    = 10'b0001000000,
    ST_LOAD  = 10'b0010000000,
    ST_MUL   = 10'b0100000000,
    ST_PUT   = 10'b1000000000
  } state_t;

  state_t state;

  logic [apd_pkg::CFG_W-1:0] cfg_count;
  logic [CW-1:0]             eff;
  logic [FW-1:0]             frame;
  logic                      has_data;
  logic [MAX_CHANNELS-1:0]   valid;
  logic [SB-1:0]             overall;

  // input fields
  logic [apd_pkg::CH_W-1:0]  in_ch;
  logic signed [SB-1:0]      in_smp;
  logic                      in_func;
  logic                      in_take;
  logic                      smp_use;
  logic                      frame_end;
  logic                      flush_go;
  logic                      blk_go;

  // update pipeline
  logic                      p1_v;
  logic [AW-1:0]             p1_addr;
  logic signed [SB-1:0]      p1_smp;
  logic                      lw_v;
  logic [AW-1:0]             lw_addr;
  logic signed [SB-1:0]      lw_hi;
  logic signed [SB-1:0]      lw_lo;
  logic signed [SB-1:0]      cur_hi;
  logic signed [SB-1:0]      cur_lo;
  logic signed [SB-1:0]      nx_hi;
  logic signed [SB-1:0]      nx_lo;

  // memory ports
  logic [AW-1:0]             raddr;
  logic [DW-1:0]             rdata;
  logic signed [SB-1:0]      rd_hi;
  logic signed [SB-1:0]      rd_lo;

  // emission datapath
  logic [CW-1:0]             idx;
  logic                      scan_pend;
  logic [AW-1:0]             scan_addr;
  logic signed [SB-1:0]      hi_max;
  logic signed [SB-1:0]      lo_min;
  logic signed [SB-1:0]      f_hi;
  logic signed [SB-1:0]      f_lo;
  logic [SB-1:0]             hi_u;
  logic [SB-1:0]             lo_mag;
  logic [SB-1:0]             pk_mag;
  logic [SW-1:0]             prod_a;
  logic [SW-1:0]             prod_b;
  logic [SW-1:0]             mix_high;
  logic [LW-1:0]             mix_low;
  logic                      is_last;
  logic                      out_free;

  // output register
  logic [apd_pkg::CH_W-1:0]  o_ch;
  logic [SW-1:0]             o_ph;
  logic [LW-1:0]             o_pl;
  logic [SW-1:0]             o_mh;
  logic [LW-1:0]             o_ml;
  logic [SB-1:0]             o_mp;

  assign in_ch   = s_tdata[apd_pkg::IN_CH_LSB +: apd_pkg::CH_W];
  assign in_smp  = s_tdata[apd_pkg::IN_SMP_LSB +: SB];
  assign in_func = s_tuser[0];

  // effective channel count: 0 acts as 1, clamp at MAX_CHANNELS
  always_comb begin
    if (cfg_count == '0) begin
      eff = CW'(1);
    end else if (int'(cfg_count) > MAX_CHANNELS) begin
      eff = CW'(MAX_CHANNELS);
    end else begin
      eff = CW'(cfg_count);
    end
  end

  // request decode
  assign s_tready  = (state == ST_IDLE);
  assign in_take   = s_tvalid && s_tready;
  assign smp_use   = in_take && (in_func == apd_pkg::FUNC_SAMPLE) && (int'(in_ch) < int'(eff));
  assign frame_end = smp_use && (int'(in_ch) + 1 == int'(eff));
  assign flush_go  = in_take && (in_func == apd_pkg::FUNC_FLUSH) && (has_data || frame != '0);
  assign blk_go    = frame_end && (frame == FW'(BLOCK_SAMPLES - 1));

  // peak memory: {high, low} per channel
  assign raddr = (state == ST_IDLE) ? AW'(in_ch) : AW'(idx);
  assign rd_hi = rdata[DW-1:SB];
  assign rd_lo = rdata[SB-1:0];

  apd_ram #(
    .WIDTH(DW),
    .DEPTH(MAX_CHANNELS)
  ) u_peak_ram (
    .clk  (clk),
    .we   (p1_v),
    .waddr(p1_addr),
    .wdata({nx_hi, nx_lo}),
    .raddr(raddr),
    .rdata(rdata)
  );

  // read-modify-write: forward last write, unwritten entries read as zero
  always_comb begin
    if (lw_v && (lw_addr == p1_addr)) begin
      cur_hi = lw_hi;
      cur_lo = lw_lo;
    end else if (valid[p1_addr]) begin
      cur_hi = rd_hi;
      cur_lo = rd_lo;
    end else begin
      cur_hi = '0;
      cur_lo = '0;
    end
    nx_hi = (p1_smp > cur_hi) ? p1_smp : cur_hi;
    nx_lo = (p1_smp < cur_lo) ? p1_smp : cur_lo;
  end

  // scan fold inputs
  assign f_hi = valid[scan_addr] ? rd_hi : '0;
  assign f_lo = valid[scan_addr] ? rd_lo : '0;

  assign is_last  = (int'(idx) + 1 == int'(eff));
  assign out_free = !m_tvalid || m_tready;

  // config register
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_count <= apd_pkg::CFG_COUNT_RESET;
    end else if (cfg_we) begin
      cfg_count <= cfg_wdata;
    end
  end

  // update pipeline stage
  always_ff @(posedge clk) begin
    if (rst) begin
      p1_v <= 1'b0;
      lw_v <= 1'b0;
    end else begin
      p1_v <= smp_use;
      lw_v <= p1_v;
    end
    p1_addr <= AW'(in_ch);
    p1_smp  <= in_smp;
    lw_addr <= p1_addr;
    lw_hi   <= nx_hi;
    lw_lo   <= nx_lo;
  end

  // control and emission sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      frame     <= '0;
      has_data  <= 1'b0;
      valid     <= '0;
      overall   <= '0;
      idx       <= '0;
      scan_pend <= 1'b0;
      m_tvalid  <= 1'b0;
    end else begin
      // result taken and no new one loaded this cycle
      if (m_tvalid && m_tready && (state != ST_PUT)) begin
        m_tvalid <= 1'b0;
      end
      if (p1_v) begin
        valid[p1_addr] <= 1'b1;
      end

      unique case (state)
        ST_IDLE: begin
          if (smp_use) begin
            has_data <= 1'b1;
          end
          if (frame_end) begin
            frame <= frame + 1'b1;
          end
          if (flush_go || blk_go) begin
            state <= ST_DRAIN;
          end
        end

        // last update writes back this cycle
        ST_DRAIN: begin
          idx       <= '0;
          scan_pend <= 1'b0;
          hi_max    <= '0;
          lo_min    <= '0;
          state     <= ST_SCAN;
        end

        // first pass: block max and min over channels in use
        ST_SCAN: begin
          if (idx != eff) begin
            scan_pend <= 1'b1;
            scan_addr <= AW'(idx);
            idx       <= idx + 1'b1;
          end else begin
            scan_pend <= 1'b0;
          end
          if (scan_pend) begin
            if (f_hi > hi_max) begin
              hi_max <= f_hi;
            end
            if (f_lo < lo_min) begin
              lo_min <= f_lo;
            end
          end
          if ((idx == eff) && !scan_pend) begin
            state <= ST_NEG;
          end
        end

        ST_NEG: begin
          hi_u   <= hi_max;
          lo_mag <= SB'(-lo_min);
          state  <= ST_MAG;
        end

        ST_MAG: begin
          pk_mag <= (hi_u > lo_mag) ? hi_u : lo_mag;
          prod_a <= apd_pkg::scale_mag(hi_u);
          prod_b <= apd_pkg::scale_mag(lo_mag);
          state  <= ST_MIX;
        end

        ST_MIX: begin
          if (pk_mag > overall) begin
            overall <= pk_mag;
          end
          mix_high <= prod_a;
          mix_low  <= LW'(0) - {1'b0, prod_b};
          idx      <= '0;
          state    <= ST_RD;
        end

        // second pass: one result per channel
        ST_RD: begin
          state <= ST_LOAD;
        end

        ST_LOAD: begin
          hi_u   <= valid[AW'(idx)] ? rd_hi : '0;
          lo_mag <= valid[AW'(idx)] ? SB'(-rd_lo) : '0;
          state  <= ST_MUL;
        end

        ST_MUL: begin
          prod_a <= apd_pkg::scale_mag(hi_u);
          prod_b <= apd_pkg::scale_mag(lo_mag);
          state  <= ST_PUT;
        end

        ST_PUT: begin
          if (out_free) begin
            m_tvalid <= 1'b1;
            m_tlast  <= is_last;
            o_ch     <= apd_pkg::CH_W'(idx);
            o_ph     <= prod_a;
            o_pl     <= LW'(0) - {1'b0, prod_b};
            o_mh     <= mix_high;
            o_ml     <= mix_low;
            o_mp     <= overall;
            if (is_last) begin
              valid    <= '0;
              frame    <= '0;
              has_data <= 1'b0;
              state    <= ST_IDLE;
            end else begin
              idx   <= idx + 1'b1;
              state <= ST_RD;
            end
          end
        end

        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  assign m_tdata = {{(apd_pkg::OUT_TDATA_W - apd_pkg::OUT_USED_W){1'b0}},
                    o_mp, o_ml, o_mh, o_pl, o_ph, o_ch};

endmodule

// ----- rtl/apd_ram.sv -----
module apd_ram #(
  parameter int WIDTH = 48,
  parameter int DEPTH = 8
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // one write port, registered read (old data on collision)
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- rtl/apd_checker.sv -----
`include "audio_peak_overview_decimator_top_defines.svh"

module apd_checker (
  input logic                            clk,
  input logic                            rst,
  input logic                            cfg_we,
  input logic [apd_pkg::CFG_W-1:0]       cfg_wdata,
  input logic                            s_tvalid,
  input logic                            s_tready,
  input logic [apd_pkg::IN_TDATA_W-1:0]  s_tdata,
  input logic [0:0]                      s_tuser,
  input logic                            m_tvalid,
  input logic                            m_tready,
  input logic [apd_pkg::OUT_TDATA_W-1:0] m_tdata,
  input logic                            m_tlast
);

  logic [apd_pkg::SCALE_BITS-1:0]  ph;
  logic [apd_pkg::SCALE_BITS-1:0]  mh;
  logic signed [apd_pkg::LOW_W-1:0] pl;
  logic signed [apd_pkg::LOW_W-1:0] ml;
  logic [apd_pkg::SAMPLE_BITS-1:0] mp;

  assign ph = m_tdata[apd_pkg::PH_LSB +: apd_pkg::SCALE_BITS];
  assign mh = m_tdata[apd_pkg::MH_LSB +: apd_pkg::SCALE_BITS];
  assign pl = m_tdata[apd_pkg::PL_LSB +: apd_pkg::LOW_W];
  assign ml = m_tdata[apd_pkg::ML_LSB +: apd_pkg::LOW_W];
  assign mp = m_tdata[apd_pkg::MP_LSB +: apd_pkg::SAMPLE_BITS];

  // stalled result holds
  `APD_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tlast), "result changed while stalled")
  // channel peaks never exceed the block mix
  `APD_ASSERT_HOLDS(a_high_order, m_tvalid, ph <= mh, "peak_high above mix_high")
  `APD_ASSERT_HOLDS(a_low_order, m_tvalid, pl >= ml, "peak_low below mix_low")
  // running peak stays within full scale
  `APD_ASSERT_HOLDS(a_peak_range, m_tvalid, mp <= apd_pkg::FULL_SCALE, "max_peak above full scale")
  // no new requests while a block is still being emitted
  `APD_ASSERT_HOLDS(a_busy_emit, m_tvalid && !m_tlast, !s_tready, "input ready mid-emission")

endmodule

bind audio_peak_overview_decimator_top apd_checker u_apd_checker (.*);
